// ----- rtl/dpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Demand paging translator package
// Shared types, register indexes, status codes and field widths.
// ----------------------------------------------------------------------------
package dpt_pkg;

	localparam int ADDR_W   = 16;
	localparam int PAGE_W   = 8;
	localparam int FRAME_W  = 7;
	localparam int STATUS_W = 2;
	localparam int LBITS_W  = 5;
	localparam int PBITS_W  = 4;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	// Register indexes (paddr[3:2]).
	localparam logic [1:0] REG_LOGICAL_BITS  = 2'd0;
	localparam logic [1:0] REG_PHYSICAL_BITS = 2'd1;
	localparam logic [1:0] REG_PAGE_BITS     = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOFRAME = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} dpt_state_t;

endpackage

// ----- rtl/dpt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle; read data is registered and held when idle.
// ----------------------------------------------------------------------------
module dpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ----- rtl/demand_paging_translator.sv -----
// ----------------------------------------------------------------------------
// Demand paging translator
// Splits a logical address into page and offset, looks the page up in a page
// table RAM and maps unmapped pages to the lowest free frame on demand.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  address   addr_valid, addr_ready, logical_address   in
//  result    result_valid, result_ready, fields         out
//  config    APB: psel penable pwrite paddr pwdata      in/out
//
// An item is handled as a page table read on the accept edge, then the lookup
// and write-back of a new mapping, held off while the result register is full.
// After reset a clearing pass writes every page table entry before the first
// address is accepted; configuration writes are taken always.
// A stalled result holds in the output register; the next address is taken
// while it waits, and its lookup waits until the register frees up.
// Frames are never released, so the in-use set is always a prefix and is kept
// as a fill count.
module demand_paging_translator #(
	parameter int MAX_PAGES  = 256,
	parameter int MAX_FRAMES = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dpt_pkg::PADDR_W-1:0]     paddr,
	input  logic [dpt_pkg::PDATA_W-1:0]     pwdata,
	output logic [dpt_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            addr_valid,
	output logic                            addr_ready,
	input  logic [dpt_pkg::ADDR_W-1:0]      logical_address,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [dpt_pkg::ADDR_W-1:0]      physical_address,
	output logic [dpt_pkg::PAGE_W-1:0]      page_number,
	output logic [dpt_pkg::FRAME_W-1:0]     frame_number,
	output logic                            page_fault,
	output logic [dpt_pkg::STATUS_W-1:0]    status
);

	import dpt_pkg::*;

	localparam int AW     = $clog2(MAX_PAGES);
	localparam int FW     = $clog2(MAX_FRAMES);
	localparam int FILL_W = $clog2(MAX_FRAMES + 1);
	localparam int EW     = FW + 1;

	// Configuration registers.
	logic [LBITS_W-1:0] logical_bits_q;
	logic [LBITS_W-1:0] physical_bits_q;
	logic [PBITS_W-1:0] page_bits_q;
	logic               cfg_wr;

	dpt_state_t st_q, st_d;
	logic [AW-1:0]     clr_q;
	logic [FILL_W-1:0] fill_q;
	logic [ADDR_W-1:0] addr_q;
	logic              outside_q;

	// RAM port.
	logic          mem_en, mem_we;
	logic [AW-1:0] mem_addr;
	logic [EW-1:0] mem_wdata, mem_rdata;

	// Accept-side decode.
	logic [ADDR_W-1:0]  in_page;
	logic [LBITS_W-1:0] pb_ext;
	logic               above_space, beyond_pages, in_outside;

	// Lookup-side decode.
	logic [ADDR_W-1:0] lk_page, lk_offset;
	logic              hit, room, alloc, out_free, out_load;
	logic [FW-1:0]     frame_sel;
	logic [31:0]       phys32, frame32;
	logic [ADDR_W-1:0] res_phys;
	logic [FRAME_W-1:0] res_frame;
	logic              res_fault;
	logic [STATUS_W-1:0] res_status;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logical_bits_q  <= LBITS_W'(16);
			physical_bits_q <= LBITS_W'(15);
			page_bits_q     <= PBITS_W'(8);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_LOGICAL_BITS:  logical_bits_q  <= pwdata[LBITS_W-1:0];
				REG_PHYSICAL_BITS: physical_bits_q <= pwdata[LBITS_W-1:0];
				REG_PAGE_BITS:     page_bits_q     <= pwdata[PBITS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LOGICAL_BITS:  prdata = PDATA_W'(logical_bits_q);
			REG_PHYSICAL_BITS: prdata = PDATA_W'(physical_bits_q);
			REG_PAGE_BITS:     prdata = PDATA_W'(page_bits_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------- accept-side range checks ----------------
	assign pb_ext  = LBITS_W'(page_bits_q);
	assign in_page = logical_address >> page_bits_q;

	always_comb begin
		above_space = (logical_bits_q < LBITS_W'(16)) &&
		              ((logical_address >> logical_bits_q) != '0);
		if (pb_ext >= logical_bits_q) begin
			beyond_pages = (in_page != '0);
		end else begin
			beyond_pages = ((in_page >> (logical_bits_q - pb_ext)) != '0);
		end
		in_outside = above_space || beyond_pages || (32'(in_page) >= MAX_PAGES);
	end

	// ---------------- lookup decode ----------------
	assign lk_page   = addr_q >> page_bits_q;
	assign lk_offset = addr_q & ((ADDR_W'(1) << page_bits_q) - ADDR_W'(1));
	assign hit       = mem_rdata[FW];

	always_comb begin
		room = (32'(fill_q) < MAX_FRAMES);
		if (pb_ext >= physical_bits_q) begin
			room = room && (fill_q == '0);
		end else begin
			room = room && ((fill_q >> (physical_bits_q - pb_ext)) == '0);
		end
	end

	always_comb begin
		alloc      = 1'b0;
		frame_sel  = mem_rdata[FW-1:0];
		res_fault  = 1'b0;
		res_status = STATUS_OK;
		priority if (outside_q) begin
			res_status = STATUS_OUTSIDE;
		end else if (hit) begin
			res_status = STATUS_OK;
		end else if (room) begin
			alloc     = 1'b1;
			frame_sel = fill_q[FW-1:0];
			res_fault = 1'b1;
		end else begin
			res_fault  = 1'b1;
			res_status = STATUS_NOFRAME;
		end
		frame32 = 32'(frame_sel);
		phys32  = (frame32 << page_bits_q) | 32'(lk_offset);
		if (res_status == STATUS_OK) begin
			res_phys  = phys32[ADDR_W-1:0];
			res_frame = frame32[FRAME_W-1:0];
		end else begin
			res_phys  = '0;
			res_frame = '0;
		end
	end

	assign out_free = !result_valid || result_ready;

	// ---------------- state machine ----------------
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLEAR:  if (clr_q == AW'(MAX_PAGES - 1)) st_d = ST_IDLE;
			ST_IDLE:   if (addr_valid) st_d = ST_LOOKUP;
			ST_LOOKUP: if (out_free) st_d = ST_IDLE;
			default:   st_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		addr_ready = 1'b0;
		mem_en     = 1'b0;
		mem_we     = 1'b0;
		mem_addr   = in_page[AW-1:0];
		mem_wdata  = '0;
		out_load   = 1'b0;
		unique case (st_q)
			ST_CLEAR: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			ST_IDLE: begin
				addr_ready = 1'b1;
				mem_en     = addr_valid;
			end
			ST_LOOKUP: begin
				out_load  = out_free;
				mem_en    = out_free && alloc;
				mem_we    = 1'b1;
				mem_addr  = lk_page[AW-1:0];
				mem_wdata = {1'b1, fill_q[FW-1:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_CLEAR;
			clr_q        <= '0;
			fill_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (out_load && alloc) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (out_load) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	// Address beat capture and result register.
	always_ff @(posedge clk) begin
		if (addr_valid && addr_ready) begin
			addr_q    <= logical_address;
			outside_q <= in_outside;
		end
		if (out_load) begin
			physical_address <= res_phys;
			page_number      <= lk_page[PAGE_W-1:0];
			frame_number     <= res_frame;
			page_fault       <= res_fault;
			status           <= res_status;
		end
	end

	dpt_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_PAGES)
	) u_page_table (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule
